/* hdl/b58d_pkg.sv */
// b58d_pkg: constants, codes, types and the alphabet lookup for the base58 text decoder
// no dependencies; every other file of the decoder refers to it by scoped names
`default_nettype none

package b58d_pkg;

    localparam int MAX_CHARS  = 64;
    localparam int ACC_WORDS  = 6;
    localparam int ACC_BITS   = 64 * ACC_WORDS;
    localparam int ACC_BYTES  = 8 * ACC_WORDS;
    localparam int RESULT_CAP = 64;
    localparam int CNT_W      = $clog2(MAX_CHARS + 1);
    localparam int REM_W      = $clog2(ACC_BYTES + 1);
    localparam int OUT_N_W    = $clog2(RESULT_CAP);
    localparam int DIGIT_W    = 6;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_CHAR = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    // characters
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;

    // snapshot of a finished string, handed to the emitter
    typedef struct packed {
        logic                valid;
        logic [1:0]          status;
        logic [CNT_W-1:0]    zero_count;
        logic [ACC_BITS-1:0] acc;
    } t_load;

    typedef struct packed {
        logic               ok;
        logic [DIGIT_W-1:0] value;
    } t_digit;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    // bitcoin alphabet, no 0 I O l
    function automatic t_digit digit_of(input logic [7:0] c);
        t_digit d;
        logic [7:0] v;
        d = '0;
        v = 8'h00;
        if (c >= 8'h31 && c <= 8'h39) begin
            v = c - 8'h31;
            d.ok = 1'b1;
        end else if (c >= 8'h41 && c <= 8'h48) begin
            v = c - 8'h41 + 8'd9;
            d.ok = 1'b1;
        end else if (c >= 8'h4a && c <= 8'h4e) begin
            v = c - 8'h4a + 8'd17;
            d.ok = 1'b1;
        end else if (c >= 8'h50 && c <= 8'h5a) begin
            v = c - 8'h50 + 8'd22;
            d.ok = 1'b1;
        end else if (c >= 8'h61 && c <= 8'h6b) begin
            v = c - 8'h61 + 8'd33;
            d.ok = 1'b1;
        end else if (c >= 8'h6d && c <= 8'h7a) begin
            v = c - 8'h6d + 8'd44;
            d.ok = 1'b1;
        end
        d.value = v[DIGIT_W-1:0];
        return d;
    endfunction

endpackage

`default_nettype wire

/* hdl/base58_text_decoder_top.sv */
// base58_text_decoder_top: streaming base58 (bitcoin alphabet) text to byte decoder
// depends on b58d_pkg, b58d_accum and b58d_emit
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------------
//  text    | in  | i_valid / o_stall  | i_char_code[7:0], i_end_of_text
//  bytes   | out | o_valid / i_stall  | o_data_byte[7:0], o_byte_present,
//          |     |                    | o_final_item, o_status[1:0]
//
// one character per cycle while not stalled via the input register, then one multiply-by-58
// and add on the 384-bit accumulator; a final character hands the string to the emitter
// the emitter gives a zero byte per leading '1', skips the value's leading zero bytes one per
// cycle, then gives the value's bytes; one result per cycle while the output is not stalled
// the next string's final character stalls until the cycle after the previous string's
// last result enters the result register; reset is synchronous, active low, no clearing pass
`default_nettype none

module base58_text_decoder_top (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_char_code,
    input  wire logic       i_end_of_text,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_data_byte,
    output logic            o_byte_present,
    output logic            o_final_item,
    output logic [1:0]      o_status
);

    // input register
    logic       r_iv;
    logic [7:0] r_char;
    logic       r_eot;

    logic            take;
    logic            emit_busy;
    b58d_pkg::t_load load;

    // stall only when a held character cannot move on
    assign o_stall = r_iv && !take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (!o_stall) begin
            r_iv <= i_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_char <= i_char_code;
            r_eot  <= i_end_of_text;
        end
    end

    // per-string state and accumulator
    b58d_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_iv),
        .i_char      (r_char),
        .i_eot       (r_eot),
        .i_emit_busy (emit_busy),
        .o_load      (load),
        .o_take      (take)
    );

    // result sequencing and result register
    b58d_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (load),
        .o_busy         (emit_busy),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_data_byte    (o_data_byte),
        .o_byte_present (o_byte_present),
        .o_final_item   (o_final_item),
        .o_status       (o_status)
    );

endmodule

`default_nettype wire

/* hdl/b58d_accum.sv */
// b58d_accum: per-string state, character checks and the multiply-by-58 accumulator
// depends on b58d_pkg; hands finished strings to b58d_emit as a t_load snapshot
`default_nettype none

module b58d_accum (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_char,
    input  wire logic          i_eot,
    input  wire logic          i_emit_busy,
    output b58d_pkg::t_load    o_load,
    output logic               o_take
);

    logic [b58d_pkg::ACC_BITS-1:0] r_acc, n_acc, v_acc, acc58;
    logic [b58d_pkg::CNT_W-1:0]    r_zc, n_zc, v_zc;
    logic [b58d_pkg::CNT_W-1:0]    r_cc, n_cc, v_cc;
    logic                          r_started, n_started, v_started;
    logic                          r_seen, n_seen, v_seen;
    logic                          r_trail, n_trail, v_trail;
    logic [1:0]                    r_err, n_err, v_err;
    b58d_pkg::t_digit              dig;

    // a final character waits while the emitter still drains the previous string
    assign o_take = i_valid && !(i_eot && i_emit_busy);

    assign dig   = b58d_pkg::digit_of(i_char);
    // x*58 = x*32 + x*16 + x*8 + x*2, wraps at the accumulator width
    assign acc58 = (r_acc << 5) + (r_acc << 4) + (r_acc << 3) + (r_acc << 1)
                 + b58d_pkg::ACC_BITS'(dig.value);

    always_comb begin
        v_acc     = r_acc;
        v_zc      = r_zc;
        v_cc      = r_cc;
        v_started = r_started;
        v_seen    = r_seen;
        v_trail   = r_trail;
        v_err     = r_err;
        if (r_err == b58d_pkg::ST_OK) begin
            if (r_cc >= b58d_pkg::CNT_W'(b58d_pkg::MAX_CHARS)) begin
                v_err = b58d_pkg::ST_TOO_LONG;
            end else begin
                v_cc = r_cc + 1'b1;
                if (b58d_pkg::is_blank(i_char)) begin
                    if (r_started) begin
                        v_trail = 1'b1;
                    end
                end else if (r_trail) begin
                    v_err = b58d_pkg::ST_BAD_CHAR;
                end else begin
                    v_started = 1'b1;
                    if (!dig.ok) begin
                        v_err = b58d_pkg::ST_BAD_CHAR;
                    end else if (!r_seen && dig.value == '0) begin
                        v_zc = r_zc + 1'b1;
                    end else begin
                        v_seen = 1'b1;
                        v_acc  = acc58;
                    end
                end
            end
        end

        n_acc     = r_acc;
        n_zc      = r_zc;
        n_cc      = r_cc;
        n_started = r_started;
        n_seen    = r_seen;
        n_trail   = r_trail;
        n_err     = r_err;
        if (o_take) begin
            if (i_eot) begin
                n_acc     = '0;
                n_zc      = '0;
                n_cc      = '0;
                n_started = 1'b0;
                n_seen    = 1'b0;
                n_trail   = 1'b0;
                n_err     = b58d_pkg::ST_OK;
            end else begin
                n_acc     = v_acc;
                n_zc      = v_zc;
                n_cc      = v_cc;
                n_started = v_started;
                n_seen    = v_seen;
                n_trail   = v_trail;
                n_err     = v_err;
            end
        end

        o_load.valid      = o_take && i_eot;
        o_load.status     = v_err;
        o_load.zero_count = v_zc;
        o_load.acc        = v_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_zc      <= '0;
            r_cc      <= '0;
            r_started <= 1'b0;
            r_seen    <= 1'b0;
            r_trail   <= 1'b0;
            r_err     <= b58d_pkg::ST_OK;
        end else begin
            r_acc     <= n_acc;
            r_zc      <= n_zc;
            r_cc      <= n_cc;
            r_started <= n_started;
            r_seen    <= n_seen;
            r_trail   <= n_trail;
            r_err     <= n_err;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cc <= b58d_pkg::CNT_W'(b58d_pkg::MAX_CHARS))
        else $error("character count beyond limit");

    a_zero_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_zc <= r_cc)
        else $error("zero prefix exceeds characters taken");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != b58d_pkg::ST_OK && !(o_take && i_eot)) |=> r_err == $past(r_err))
        else $error("recorded error changed before end of string");
`endif

endmodule

`default_nettype wire

/* hdl/b58d_emit.sv */
// b58d_emit: walks a finished string snapshot out as result items through the result register
// depends on b58d_pkg; fed by b58d_accum through a t_load snapshot
`default_nettype none

module b58d_emit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire b58d_pkg::t_load i_load,
    output logic               o_busy,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [7:0]         o_data_byte,
    output logic               o_byte_present,
    output logic               o_final_item,
    output logic [1:0]         o_status
);

    logic                          r_act, n_act;
    logic [1:0]                    r_stat, n_stat;
    logic [b58d_pkg::CNT_W-1:0]    r_zc, n_zc;
    logic [b58d_pkg::ACC_BITS-1:0] r_acc, n_acc;
    logic [b58d_pkg::REM_W-1:0]    r_rem, n_rem;
    logic                          r_sig, n_sig;
    logic [b58d_pkg::OUT_N_W-1:0]  r_n, n_n;

    logic                          r_ov;
    logic [7:0]                    r_data;
    logic                          r_pres, r_fin;
    logic [1:0]                    r_ostat;

    logic       can_load, produce, done, nz, at_cap;
    logic [7:0] top, p_data;
    logic       p_pres, p_fin;
    logic [1:0] p_stat;

    assign can_load = !r_ov || !i_stall;
    assign nz       = |r_acc;
    assign top      = r_acc[b58d_pkg::ACC_BITS-1 -: 8];
    assign at_cap   = (r_n == b58d_pkg::OUT_N_W'(b58d_pkg::RESULT_CAP - 1));

    always_comb begin
        n_act   = r_act;
        n_stat  = r_stat;
        n_zc    = r_zc;
        n_acc   = r_acc;
        n_rem   = r_rem;
        n_sig   = r_sig;
        n_n     = r_n;
        produce = 1'b0;
        done    = 1'b0;
        p_data  = 8'h00;
        p_pres  = 1'b0;
        p_fin   = 1'b0;
        p_stat  = b58d_pkg::ST_OK;
        if (r_act) begin
            if (r_stat != b58d_pkg::ST_OK) begin
                produce = 1'b1;
                p_fin   = 1'b1;
                p_stat  = r_stat;
                done    = can_load;
            end else if (r_zc != '0) begin
                produce = 1'b1;
                p_pres  = 1'b1;
                p_fin   = (r_zc == b58d_pkg::CNT_W'(1) && !nz) || at_cap;
                if (can_load) begin
                    n_zc = r_zc - 1'b1;
                    n_n  = r_n + 1'b1;
                    done = p_fin;
                end
            end else if (!r_sig && !nz) begin
                // empty or all-blank string
                produce = 1'b1;
                p_fin   = 1'b1;
                done    = can_load;
            end else if (!r_sig && top == 8'h00) begin
                // drop a leading zero byte, no result
                n_acc = {r_acc[b58d_pkg::ACC_BITS-9:0], 8'h00};
                n_rem = r_rem - 1'b1;
            end else begin
                produce = 1'b1;
                p_data  = top;
                p_pres  = 1'b1;
                p_fin   = (r_rem == b58d_pkg::REM_W'(1)) || at_cap;
                if (can_load) begin
                    n_acc = {r_acc[b58d_pkg::ACC_BITS-9:0], 8'h00};
                    n_rem = r_rem - 1'b1;
                    n_sig = 1'b1;
                    n_n   = r_n + 1'b1;
                    done  = p_fin;
                end
            end
        end
        if (done) begin
            n_act = 1'b0;
        end
        if (i_load.valid) begin
            n_act  = 1'b1;
            n_stat = i_load.status;
            n_zc   = i_load.zero_count;
            n_acc  = i_load.acc;
            n_rem  = b58d_pkg::REM_W'(b58d_pkg::ACC_BYTES);
            n_sig  = 1'b0;
            n_n    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_stat <= b58d_pkg::ST_OK;
            r_zc   <= '0;
            r_rem  <= '0;
            r_sig  <= 1'b0;
            r_n    <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_act  <= n_act;
            r_stat <= n_stat;
            r_zc   <= n_zc;
            r_rem  <= n_rem;
            r_sig  <= n_sig;
            r_n    <= n_n;
            if (can_load) begin
                r_ov <= produce;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (can_load) begin
            r_data  <= p_data;
            r_pres  <= p_pres;
            r_fin   <= p_fin;
            r_ostat <= p_stat;
        end
    end

    assign o_busy         = r_act;
    assign o_valid        = r_ov;
    assign o_data_byte    = r_data;
    assign o_byte_present = r_pres;
    assign o_final_item   = r_fin;
    assign o_status       = r_ostat;

`ifndef SYNTH
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load.valid |-> !r_act)
        else $error("new string handed over while emitter busy");

    a_empty_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_pres) |-> r_fin)
        else $error("byteless result not marked final");

    a_err_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ostat != b58d_pkg::ST_OK) |-> (!r_pres && r_data == 8'h00))
        else $error("error result carries a byte");
`endif

endmodule

`default_nettype wire
